### src/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LCC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define LCC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### src/lcc_pkg.sv
package lcc_pkg;

	localparam int CARD_W     = 54;
	localparam int BCD_DIGITS = 17;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int BIT_CNT_W  = 6;
	localparam int DIGIT_CNT_W = 5;

	localparam logic [BIT_CNT_W-1:0]   DABBLE_LAST = BIT_CNT_W'(CARD_W - 1);
	localparam logic [DIGIT_CNT_W-1:0] DIGIT_CNT_MAX = DIGIT_CNT_W'(BCD_DIGITS);

	// lengths that may carry a brand
	localparam logic [DIGIT_CNT_W-1:0] LEN_SHORT = 5'd13;
	localparam logic [DIGIT_CNT_W-1:0] LEN_MID   = 5'd15;
	localparam logic [DIGIT_CNT_W-1:0] LEN_LONG  = 5'd16;

	// leading digit pairs
	localparam logic [3:0] AMEX_HI   = 4'd3;
	localparam logic [3:0] AMEX_LO_A = 4'd4;
	localparam logic [3:0] AMEX_LO_B = 4'd7;
	localparam logic [3:0] MC_HI     = 4'd5;
	localparam logic [3:0] MC_LO_MIN = 4'd1;
	localparam logic [3:0] MC_LO_MAX = 4'd5;
	localparam logic [3:0] VISA_HI   = 4'd4;

	typedef enum logic [1:0] {
		BRAND_INVALID,
		BRAND_AMEX,
		BRAND_MASTERCARD,
		BRAND_VISA
	} lcc_brand_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN
	} lcc_state_t;

	typedef struct packed {
		logic load;
		logic dabble;
		logic shift_digit;
	} lcc_cmd_t;

	// doubled digit folded to the sum of its decimal digits
	function automatic logic [3:0] double_fold(input logic [3:0] d);
		logic [4:0] d2;
		d2 = {d, 1'b0};
		if (d2 >= 5'd10) begin
			d2 = d2 - 5'd9;
		end
		return d2[3:0];
	endfunction

	function automatic logic [3:0] add_mod10(input logic [3:0] s, input logic [3:0] d);
		logic [4:0] t;
		t = {1'b0, s} + {1'b0, d};
		if (t >= 5'd10) begin
			t = t - 5'd10;
		end
		return t[3:0];
	endfunction

	function automatic lcc_brand_t brand_of(input logic [3:0] hi, input logic [3:0] lo);
		lcc_brand_t b;
		b = BRAND_INVALID;
		case (hi)
			AMEX_HI: begin
				if (lo == AMEX_LO_A || lo == AMEX_LO_B) begin
					b = BRAND_AMEX;
				end
			end
			MC_HI: begin
				if (lo inside {[MC_LO_MIN:MC_LO_MAX]}) begin
					b = BRAND_MASTERCARD;
				end
			end
			VISA_HI: begin
				b = BRAND_VISA;
			end
			default: begin
				b = BRAND_INVALID;
			end
		endcase
		return b;
	endfunction

endpackage

### src/luhn_card_number_check.sv
// sequence: the binary to bcd shifter converts one bit a cycle, then the digits are
// scanned one per cycle until the bcd register is zero, then the result is loaded
// a new card number is taken only in idle, once the last result is loaded; the
// next beat is taken while a result waits
// reset: arst_n clears the sequencer and the output valid, the block comes up idle
`include "assert_macros.svh"

module luhn_card_number_check
	import lcc_pkg::*;
#(
	parameter int MAX_DIGITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CARD_W-1:0] card_value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        brand,
	output logic              luhn_ok,
	output logic [4:0]        digit_total
);

	localparam logic [DIGIT_CNT_W-1:0] MaxLen = DIGIT_CNT_W'(MAX_DIGITS);

	lcc_state_t state_q, state_d;
	lcc_cmd_t   cmd;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [DIGIT_CNT_W-1:0] digit_cnt_q;
	logic [3:0] sum_q;
	logic [3:0] hi_q;
	logic [3:0] lo_q;
	logic [3:0] digit;
	logic [3:0] digit_term;
	logic       bcd_zero;
	logic       take_digit;
	logic       write_out;
	logic       len_ok;
	lcc_brand_t brand_d;

	logic       out_valid_q;
	lcc_brand_t brand_q;
	logic       luhn_ok_q;
	logic [DIGIT_CNT_W-1:0] digit_total_q;

	lcc_dabble_unit u_dabble (
		.clk        (clk),
		.cmd        (cmd),
		.card_value (card_value),
		.digit      (digit),
		.bcd_zero   (bcd_zero)
	);

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		take_digit = 1'b0;
		write_out  = 1'b0;
		in_stall   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.dabble = 1'b1;
				if (bit_cnt_q == DABBLE_LAST) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!bcd_zero) begin
					cmd.shift_digit = 1'b1;
					take_digit      = 1'b1;
				end else if (!out_valid_q || !out_stall) begin
					write_out = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// even positions from the right are doubled
	assign digit_term = digit_cnt_q[0] ? double_fold(digit) : digit;

	assign len_ok = (digit_cnt_q == LEN_SHORT || digit_cnt_q == LEN_MID ||
		digit_cnt_q == LEN_LONG) && (digit_cnt_q <= MaxLen);
	assign brand_d = (sum_q == 4'd0 && len_ok) ? brand_of(hi_q, lo_q) : BRAND_INVALID;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_cnt_q   <= '0;
			digit_cnt_q <= '0;
			sum_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				bit_cnt_q   <= '0;
				digit_cnt_q <= '0;
				sum_q       <= '0;
			end else begin
				if (cmd.dabble) begin
					bit_cnt_q <= bit_cnt_q + 1'b1;
				end
				if (take_digit) begin
					digit_cnt_q <= digit_cnt_q + 1'b1;
					sum_q       <= add_mod10(sum_q, digit_term);
				end
			end
		end
	end

	// last two digits taken are the leading pair
	always_ff @(posedge clk) begin
		if (take_digit) begin
			hi_q <= digit;
			lo_q <= hi_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (write_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (write_out) begin
			brand_q       <= brand_d;
			luhn_ok_q     <= (sum_q == 4'd0);
			digit_total_q <= digit_cnt_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign brand       = brand_q;
	assign luhn_ok     = luhn_ok_q;
	assign digit_total = digit_total_q;

	`LCC_ASSERT(a_rose_from_scan, clk, arst_n, $rose(out_valid) |-> $past(state_q == ST_SCAN), "result beat appeared outside the digit scan")
	`LCC_ASSERT(a_digit_bound, clk, arst_n, digit_cnt_q <= DIGIT_CNT_MAX, "digit count beyond bcd width")
	`LCC_ASSERT(a_conv_bound, clk, arst_n, (state_q == ST_CONV) |-> (bit_cnt_q <= DABBLE_LAST), "conversion ran past the input width")
	`LCC_ASSERT(a_accept_starts, clk, arst_n, (in_valid && !in_stall) |=> (state_q == ST_CONV && bit_cnt_q == '0), "accepted beat did not start conversion")
	`LCC_ASSERT_ALWAYS(a_no_write_on_full, clk, (write_out && out_valid_q) |-> !out_stall, "result overwritten while stalled")

endmodule

### src/lcc_dabble_unit.sv
module lcc_dabble_unit
	import lcc_pkg::*;
(
	input  logic              clk,
	input  lcc_cmd_t          cmd,
	input  logic [CARD_W-1:0] card_value,
	output logic [3:0]        digit,
	output logic              bcd_zero
);

	logic [CARD_W-1:0] bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [BCD_W-1:0]  adj;

	// add 3 to every nibble of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= card_value;
			bcd_q <= '0;
		end else if (cmd.dabble) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[CARD_W-1]};
			bin_q <= {bin_q[CARD_W-2:0], 1'b0};
		end else if (cmd.shift_digit) begin
			bcd_q <= {4'd0, bcd_q[BCD_W-1:4]};
		end
	end

	assign digit    = bcd_q[3:0];
	assign bcd_zero = (bcd_q == '0);

endmodule

### bench/tb_top.sv
typedef struct {
	lcc_pkg::lcc_brand_t brand;
	logic                luhn_ok;
	logic [4:0]          digits;
} card_verdict_t;

class luhn_scoreboard;
	card_verdict_t pending_verdicts[$];
	int            max_len;
	int            mismatches;

	function new(int max_len_i);
		max_len = max_len_i;
		mismatches = 0;
	endfunction

	// doubled digits at even places from the right, folded back to one digit
	function longint unsigned digit_sum(input logic [53:0] v, output int count);
		longint unsigned rest;
		longint unsigned total;
		int              d;
		rest = 64'(v);
		total = 0;
		count = 0;
		while (rest != 0) begin
			d = int'(rest % 10);
			count++;
			if (count % 2 == 0) begin
				d = d * 2;
				d = d / 10 + d % 10;
			end
			total += 64'(d);
			rest /= 10;
		end
		return total;
	endfunction

	function card_verdict_t expected_verdict(input logic [53:0] v);
		card_verdict_t   e;
		longint unsigned total;
		longint unsigned pair;
		int              count;
		total = digit_sum(v, count);
		e.luhn_ok = (total % 10 == 0);
		e.digits = count[4:0];
		e.brand = lcc_pkg::BRAND_INVALID;
		pair = 64'(v);
		while (pair >= 100) begin
			pair /= 10;
		end
		if (e.luhn_ok && count <= max_len && (count == int'(lcc_pkg::LEN_SHORT) ||
				count == int'(lcc_pkg::LEN_MID) || count == int'(lcc_pkg::LEN_LONG))) begin
			if (pair == 34 || pair == 37) begin
				e.brand = lcc_pkg::BRAND_AMEX;
			end else if (pair >= 51 && pair <= 55) begin
				e.brand = lcc_pkg::BRAND_MASTERCARD;
			end else if (pair >= 40 && pair <= 49) begin
				e.brand = lcc_pkg::BRAND_VISA;
			end
		end
		return e;
	endfunction

	function void note_card(input logic [53:0] v);
		pending_verdicts.push_back(expected_verdict(v));
	endfunction

	function void check_verdict(input logic [1:0] b, input logic ok, input logic [4:0] n);
		card_verdict_t e;
		if (pending_verdicts.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("unexpected result beat: brand=%0d luhn_ok=%0d digits=%0d", b, ok, n);
			end
			return;
		end
		e = pending_verdicts.pop_front();
		if (b !== e.brand || ok !== e.luhn_ok || n !== e.digits) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch: brand exp %0d got %0d, luhn_ok exp %0d got %0d, digits exp %0d got %0d",
					e.brand, b, e.luhn_ok, ok, e.digits, n);
			end
		end
	endfunction

	function int outstanding();
		return pending_verdicts.size();
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lcc_pkg::*;

	localparam int MAX_LEN = 16;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [CARD_W-1:0] card_value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        brand;
	logic              luhn_ok;
	logic [4:0]        digit_total;

	luhn_scoreboard sb = new(MAX_LEN);
	bit             send_gaps = 1'b1;
	bit             recv_gaps = 1'b1;
	int             hold_left = 0;

	luhn_card_number_check #(.MAX_DIGITS(MAX_LEN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.card_value(card_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.brand(brand),
		.luhn_ok(luhn_ok),
		.digit_total(digit_total)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("** luhn_card_number_check: FAILED **");
		$finish;
	end

	// result side: check accepted beats, stall at random or through a long hold
	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				sb.check_verdict(brand, luhn_ok, digit_total);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= recv_gaps && ($urandom_range(99) < 12);
			end
		end
	end

	// number of len digits starting with lead, luhn-valid or made to fail
	function automatic logic [53:0] make_card(input int len, input int lead, input bit pass);
		longint unsigned v;
		longint unsigned total;
		int              count;
		v = 64'(lead);
		for (int i = 2; i < len - 1; i++) begin
			v = v * 10 + 64'($urandom_range(9));
		end
		v = v * 10;
		total = sb.digit_sum(v[53:0], count);
		v += (10 - total % 10) % 10;
		if (!pass) begin
			v = (v % 10 == 9) ? v - 1 : v + 1;
		end
		return v[53:0];
	endfunction

	function automatic int pick_lead();
		int prefixes[17] = '{34, 37, 51, 52, 53, 54, 55, 40, 41, 42, 43, 44, 45, 46, 47, 48, 49};
		if ($urandom_range(99) < 70) begin
			return prefixes[$urandom_range(16)];
		end
		return $urandom_range(10, 99);
	endfunction

	function automatic logic [53:0] random_card();
		int r;
		int len;
		int lens[3] = '{13, 15, 16};
		r = $urandom_range(99);
		if (r < 55) begin
			return make_card(lens[$urandom_range(2)], pick_lead(), $urandom_range(99) < 85);
		end else if (r < 75) begin
			len = $urandom_range(1, 17);
			if (len == 1) begin
				return 54'($urandom_range(9));
			end
			return make_card(len, (len == 17) ? $urandom_range(10, 17) : $urandom_range(10, 99),
				$urandom_range(1) == 1);
		end else if (r < 95) begin
			return 54'({$urandom, $urandom});
		end
		return 54'($urandom_range(999));
	endfunction

	// called at a rising edge; returns at the edge where the beat was taken, or after a random gap with in_valid low
	task automatic send_card(input logic [53:0] v);
		in_valid <= 1'b1;
		card_value <= v;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_card(v);
		if (send_gaps && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			card_value <= 54'({$urandom, $urandom});
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_card(54'd0);
		send_card(54'd1);
		send_card(54'd9);
		send_card(54'd18);
		send_card({54{1'b1}});
		send_card(54'd9999999999999999);
		send_card(54'd10000000000000000);
		send_card(make_card(15, 34, 1));
		send_card(make_card(15, 37, 1));
		send_card(make_card(16, 51, 1));
		send_card(make_card(16, 55, 1));
		send_card(make_card(16, 40, 1));
		send_card(make_card(13, 49, 1));
		send_card(make_card(15, 45, 1));
		send_card(make_card(13, 34, 1));
		send_card(make_card(16, 50, 1));
		send_card(make_card(16, 56, 1));
		send_card(make_card(16, 33, 1));
		send_card(make_card(14, 41, 1));
		send_card(make_card(12, 41, 1));
		send_card(make_card(17, 15, 1));
		send_card(make_card(16, 42, 0));
		send_card(make_card(15, 37, 0));

		for (int i = 0; i < 800; i++) begin
			send_gaps = !(i >= 300 && i < 500);
			recv_gaps = send_gaps;
			// long hold on the result side while numbers keep coming
			if (i == 600) begin
				hold_left = 400;
			end
			send_card(random_card());
		end
		in_valid <= 1'b0;

		while (sb.outstanding() != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("** luhn_card_number_check: PASSED **");
		end else begin
			$display("** luhn_card_number_check: FAILED **");
		end
		$finish;
	end
endmodule

### files.f
+incdir+src
src/lcc_pkg.sv
src/lcc_dabble_unit.sv
src/luhn_card_number_check.sv
bench/tb_top.sv
